/* rtl/core/i2p_pkg.sv */
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, character codes and precedence lookup for the converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    typedef enum logic [1:0] {
        K_LETTER = 2'd0,
        K_LPAREN = 2'd1,
        K_RPAREN = 2'd2,
        K_OPER   = 2'd3
    } t_kind;

    // precedence: 0 = none (-1), 1 = + -, 2 = * /, 3 = ^
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  prio;
        logic [7:0]  ch;
        logic        last;
    } t_item;

    function automatic logic [1:0] prio_of(input logic [7:0] ch);
        logic [1:0] p;
        p = 2'd0;
        if (ch == CH_CARET) begin
            p = 2'd3;
        end else if (ch == CH_STAR || ch == CH_SLASH) begin
            p = 2'd2;
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            p = 2'd1;
        end
        return p;
    endfunction

    function automatic logic is_letter(input logic [7:0] ch);
        return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    endfunction

endpackage

/* rtl/core/i2p_ram.sv */
// ----------------------------------------------------------------------------
// i2p_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/i2p_front.sv */
// ----------------------------------------------------------------------------
// i2p_front
// Accepts input characters, classifies them and queues them for the stack
// engine in a two-entry queue.
// ----------------------------------------------------------------------------
module i2p_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,
    input  logic           s_axis_tlast,
    output logic           o_item_valid,
    output i2p_pkg::t_item o_item,
    input  logic           i_item_pop
);

    i2p_pkg::t_item r_mem [2];
    logic           r_wptr, n_wptr;
    logic           r_rptr, n_rptr;
    logic [1:0]     r_cnt, n_cnt;
    i2p_pkg::t_item item;
    logic           push;

    always_comb begin
        item.ch   = s_axis_tdata;
        item.last = s_axis_tlast;
        item.prio = i2p_pkg::prio_of(s_axis_tdata);
        if (i2p_pkg::is_letter(s_axis_tdata)) begin
            item.kind = i2p_pkg::K_LETTER;
        end else if (s_axis_tdata == i2p_pkg::CH_LPAREN) begin
            item.kind = i2p_pkg::K_LPAREN;
        end else if (s_axis_tdata == i2p_pkg::CH_RPAREN) begin
            item.kind = i2p_pkg::K_RPAREN;
        end else begin
            item.kind = i2p_pkg::K_OPER;
        end
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_item_valid  = (r_cnt != 2'd0);
    assign o_item        = r_mem[r_rptr];

    always_comb begin
        n_wptr = push ? ~r_wptr : r_wptr;
        n_rptr = i_item_pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(push) - 2'(i_item_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= item;
        end
    end

endmodule

/* rtl/core/i2p_engine.sv */
// ----------------------------------------------------------------------------
// i2p_engine
// Operator stack and sequencer: pops, pushes and flushes at most one step a
// cycle, holds one result back to mark the last of each request.
// ----------------------------------------------------------------------------
module i2p_engine #(
    parameter int STACK_DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  i2p_pkg::t_item i_item,
    output logic           o_item_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [7:0]     m_axis_tdata,
    output logic           m_axis_tlast,
    output logic [1:0]     m_axis_tuser
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_END  = 3'b100
    } t_state;

    t_state         r_state, n_state;
    i2p_pkg::t_item r_cur;
    logic [CW-1:0]  r_count;
    logic [7:0]     r_top;
    logic           r_settled;
    logic           r_ovf;
    logic [7:0]     r_pend;
    logic           r_pend_valid;
    logic           r_out_valid;
    logic [7:0]     r_out_ch;
    logic           r_out_last;
    logic           r_out_done;
    logic           r_out_ovf;

    logic           out_free, pop_ok, full, empty;
    logic           do_pop, do_push, emit, finish, load;
    logic [7:0]     emit_ch;
    logic           ram_we;
    logic [CW-1:0]  wa_full, ra_full;
    logic [7:0]     ram_rdata;

    assign out_free = !r_out_valid || m_axis_tready;
    assign empty    = (r_count == '0);
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign pop_ok   = (r_count < CW'(2)) || r_settled;
    assign wa_full  = r_count - CW'(1);
    assign ra_full  = r_count - CW'(2);
    assign ram_we   = do_push && !full && !empty;

    i2p_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wa_full[AW-1:0]),
        .i_wdata (r_top),
        .i_raddr (ra_full[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        do_pop  = 1'b0;
        do_push = 1'b0;
        emit    = 1'b0;
        emit_ch = r_top;
        finish  = 1'b0;
        load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    load    = 1'b1;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                unique case (r_cur.kind)
                    i2p_pkg::K_LETTER: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            emit_ch = r_cur.ch;
                            n_state = S_END;
                        end
                    end
                    i2p_pkg::K_LPAREN: begin
                        do_push = 1'b1;
                        n_state = S_END;
                    end
                    i2p_pkg::K_RPAREN: begin
                        if (empty) begin
                            n_state = S_END;
                        end else if (r_top == i2p_pkg::CH_LPAREN) begin
                            if (pop_ok) begin
                                do_pop  = 1'b1;
                                n_state = S_END;
                            end
                        end else if (pop_ok && out_free) begin
                            do_pop = 1'b1;
                            emit   = 1'b1;
                        end
                    end
                    i2p_pkg::K_OPER: begin
                        if (!empty && (i2p_pkg::prio_of(r_top) > r_cur.prio)) begin
                            if (pop_ok && out_free) begin
                                do_pop = 1'b1;
                                emit   = 1'b1;
                            end
                        end else begin
                            do_push = 1'b1;
                            n_state = S_END;
                        end
                    end
                    default: ;
                endcase
            end
            S_END: begin
                if (r_cur.last && !empty) begin
                    if (pop_ok && out_free) begin
                        do_pop = 1'b1;
                        emit   = 1'b1;
                    end
                end else if (!r_pend_valid || out_free) begin
                    finish = 1'b1;
                    if (i_item_valid) begin
                        load    = 1'b1;
                        n_state = S_RUN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_item_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_settled    <= 1'b0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_settled <= !(do_pop || (do_push && !full));
            if (do_pop) begin
                r_count <= r_count - CW'(1);
            end else if (do_push) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (emit) begin
                r_pend_valid <= 1'b1;
            end else if (finish) begin
                r_pend_valid <= 1'b0;
                if (r_cur.last) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
            if ((emit || finish) && r_pend_valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_item;
        end
        if (do_pop) begin
            r_top <= ram_rdata;
        end else if (do_push && !full) begin
            r_top <= r_cur.ch;
        end
        if (emit) begin
            r_pend <= emit_ch;
        end
        if ((emit || finish) && r_pend_valid) begin
            r_out_ch   <= r_pend;
            r_out_last <= finish;
            r_out_done <= finish && r_cur.last;
            r_out_ovf  <= r_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_ch;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_ovf, r_out_done};

endmodule

/* rtl/core/infix_to_postfix_converter.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard infix to postfix converter with an operator stack in RAM.
// ----------------------------------------------------------------------------
// channel   dir  tdata          tlast      tuser
// s_axis    in   char_in        expr_end   -
// m_axis    out  char_out       run_last   [0] expr_done, [1] overflow
//
// A character passes through its step and a closing state that also takes the
// next request, with a further step per stack pop. With two or more entries
// stacked, a pop right after a pop or a push waits for the RAM read of the
// entry below the top. A two-entry queue lets input keep
// arriving while the engine works; the output register holds a result under
// stall. Reset is synchronous, active low, and empties the stack at once.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] char_out
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser    // [0] expr_done, [1] overflow
);

    logic           item_valid;
    logic           item_pop;
    i2p_pkg::t_item item;

    i2p_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_item_pop    (item_pop)
    );

    i2p_engine #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_pop    (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* verif/infix_to_postfix_converter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb
// Streams infix characters into the converter and checks every postfix
// character, with its run_last, expr_done and overflow flags, against a
// behavioral operator-stack model kept inside the bench. Directed expressions
// come first, then a full-stack run, an output stall that backs up the input,
// and random expressions under three idle patterns.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;

    localparam int STACK_DEPTH     = 32;
    localparam int HOLD_CYCLES     = 200;
    localparam int DRAIN_CYCLES    = 100;
    localparam int ITEMS_PER_PHASE = 14;
    localparam int TIMEOUT_NS      = 1_000_000;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       expr_done;
        logic       ovf;
    } t_postfix_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_in
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] char_out
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;           // [0] expr_done, [1] overflow

    t_postfix_char postfix_expected[$];
    logic [7:0]    model_stack [STACK_DEPTH];
    int            model_depth = 0;
    logic          model_ovf = 1'b0;

    int fail_count    = 0;
    int requests_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // ---------------- operator-stack model ----------------

    function automatic i2p_pkg::t_kind kind_of(input logic [7:0] c);
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            return i2p_pkg::K_LETTER;
        end else if (c == i2p_pkg::CH_LPAREN) begin
            return i2p_pkg::K_LPAREN;
        end else if (c == i2p_pkg::CH_RPAREN) begin
            return i2p_pkg::K_RPAREN;
        end
        return i2p_pkg::K_OPER;
    endfunction

    function automatic int rank_of(input logic [7:0] c);
        unique case (c)
            i2p_pkg::CH_CARET:                   return 3;
            i2p_pkg::CH_STAR, i2p_pkg::CH_SLASH: return 2;
            i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS: return 1;
            default:                             return -1;
        endcase
    endfunction

    function automatic void stack_push(input logic [7:0] c);
        if (model_depth >= STACK_DEPTH) begin
            model_ovf = 1'b1;
        end else begin
            model_stack[model_depth] = c;
            model_depth++;
        end
    endfunction

    task automatic predict_char(input logic [7:0] c, input logic last);
        t_postfix_char run[$];
        int            rank;
        int            k;
        unique case (kind_of(c))
            i2p_pkg::K_LETTER: run.insert(run.size(), t_postfix_char'{c, 1'b0, 1'b0, 1'b0});
            i2p_pkg::K_LPAREN: stack_push(c);
            i2p_pkg::K_RPAREN: begin
                while (model_depth > 0 && model_stack[model_depth - 1] != i2p_pkg::CH_LPAREN) begin
                    model_depth--;
                    run.insert(run.size(),
                               t_postfix_char'{model_stack[model_depth], 1'b0, 1'b0, 1'b0});
                end
                if (model_depth > 0) begin
                    model_depth--;
                end
            end
            default: begin
                rank = rank_of(c);
                while (model_depth > 0 && rank_of(model_stack[model_depth - 1]) > rank) begin
                    model_depth--;
                    run.insert(run.size(),
                               t_postfix_char'{model_stack[model_depth], 1'b0, 1'b0, 1'b0});
                end
                stack_push(c);
            end
        endcase
        if (last) begin
            while (model_depth > 0) begin
                model_depth--;
                run.insert(run.size(),
                           t_postfix_char'{model_stack[model_depth], 1'b0, 1'b0, 1'b0});
            end
        end
        for (k = 0; k < run.size(); k++) begin
            run[k].ovf = model_ovf;
        end
        if (run.size() > 0) begin
            run[run.size() - 1].run_last  = 1'b1;
            run[run.size() - 1].expr_done = last;
        end
        for (k = 0; k < run.size(); k++) begin
            postfix_expected.insert(postfix_expected.size(), run[k]);
        end
        if (last) begin
            model_depth = 0;
            model_ovf   = 1'b0;
        end
    endtask

    // ---------------- result checking ----------------

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_postfix_char want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (postfix_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual ch=%h last=%b user=%b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                fail_count++;
            end else begin
                want = postfix_expected.pop_front();
                check_field("char_out", want.ch, m_axis_tdata);
                check_field("run_last", want.run_last, m_axis_tlast);
                check_field("expr_done", want.expr_done, m_axis_tuser[0]);
                check_field("overflow", want.ovf, m_axis_tuser[1]);
            end
        end
    end

    // ---------------- receiver ----------------

    initial begin : receiver
        int holds_served;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- sender ----------------

    task automatic send_char(input logic [7:0] ch, input logic last);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_char(ch, last);
        requests_sent++;
    endtask

    task automatic send_string(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            send_char(s[k], k == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1) == 1) begin
            return 8'h41 + 8'($urandom_range(25));
        end
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] random_operator();
        unique case ($urandom_range(4))
            0:       return i2p_pkg::CH_CARET;
            1:       return i2p_pkg::CH_STAR;
            2:       return i2p_pkg::CH_SLASH;
            3:       return i2p_pkg::CH_PLUS;
            default: return i2p_pkg::CH_MINUS;
        endcase
    endfunction

    task automatic send_expression();
        int  operands;
        int  depth;
        int  closes;
        int  n;
        int  k;
        logic is_final;
        operands = $urandom_range(1, 10);
        depth    = 0;
        for (n = 0; n < operands; n++) begin
            is_final = (n == operands - 1);
            while (depth < 6 && $urandom_range(99) < 25) begin
                send_char(i2p_pkg::CH_LPAREN, 1'b0);
                depth++;
            end
            send_char(random_letter(), is_final && depth == 0);
            if (is_final) begin
                closes = depth;
            end else begin
                closes = ($urandom_range(2) == 0) ? $urandom_range(depth) : 0;
            end
            for (k = 0; k < closes; k++) begin
                send_char(i2p_pkg::CH_RPAREN, is_final && k == closes - 1);
            end
            depth -= closes;
            if (!is_final) begin
                send_char(random_operator(), 1'b0);
            end
        end
    endtask

    task automatic send_noise();
        int        count;
        int        k;
        logic [7:0] c;
        count = $urandom_range(1, 6);
        for (k = 0; k < count; k++) begin
            unique case ($urandom_range(3))
                0:       c = 8'($urandom_range(255));
                1:       c = random_letter();
                2:       c = random_operator();
                default: c = ($urandom_range(1) == 1) ? i2p_pkg::CH_LPAREN : i2p_pkg::CH_RPAREN;
            endcase
            send_char(c, $urandom_range(3) == 0);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_basics();
        send_string("A+b*C^z/Y-a");
        send_string("(a+b)*c");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        // characters just outside the letter ranges
        send_char(8'h60, 1'b0);
        send_char(8'h7B, 1'b0);
        send_char(i2p_pkg::CH_CARET, 1'b1);
    endtask

    task automatic test_special_cases();
        send_string("a*(b");       // leftover open paren flushed
        send_string("a+b)c");      // close paren without a match
        send_string("()");         // end request with nothing to emit
        send_char(i2p_pkg::CH_RPAREN, 1'b1);
        send_string("x");
    endtask

    task automatic test_stack_overflow();
        int k;
        send_char("a", 1'b0);
        for (k = 0; k <= STACK_DEPTH; k++) begin
            send_char(i2p_pkg::CH_LPAREN, 1'b0);
        end
        send_char("b", 1'b1);
        // overflow again, then drain to empty so the end clears it silently
        for (k = 0; k <= STACK_DEPTH; k++) begin
            send_char(i2p_pkg::CH_LPAREN, 1'b0);
        end
        for (k = 0; k <= STACK_DEPTH; k++) begin
            send_char(i2p_pkg::CH_RPAREN, k == STACK_DEPTH);
        end
        send_string("q");
    endtask

    task automatic test_output_backpressure();
        int k;
        hold_requests <= hold_requests + 1;
        for (k = 0; k < 15; k++) begin
            send_char(random_letter(), k == 14);
            if (k != 14) begin
                send_char(random_operator(), 1'b0);
            end
        end
    endtask

    task automatic test_random_expressions(input int tx_idle, input int rx_idle);
        int start;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        start = requests_sent;
        while (requests_sent - start < ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 80) begin
                send_expression();
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin : main
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_basics();
        test_special_cases();
        test_stack_overflow();
        test_output_backpressure();
        test_random_expressions(24, 87);
        test_random_expressions(87, 24);
        test_random_expressions(0, 0);
        s_axis_tvalid <= 1'b0;
        while (postfix_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* infix_to_postfix_converter.f */
rtl/core/i2p_pkg.sv
rtl/core/i2p_ram.sv
rtl/core/i2p_front.sv
rtl/core/i2p_engine.sv
rtl/core/infix_to_postfix_converter.sv
verif/infix_to_postfix_converter_tb.sv
